>>> src/spjh_pkg.sv
// shared types and constants for the spike pattern joint histogram
package spjh_pkg;

    localparam int BIN_W     = 16;
    localparam int HIST_DEPTH = 1 << BIN_W;
    localparam int SIDX_W    = 16;
    localparam int CNT_OUT_W = 32;
    localparam int APB_DW    = 32;
    localparam int ADDR_W    = 5;

    localparam logic [2:0] REG_X_ORDER  = 3'd0;
    localparam logic [2:0] REG_Y_ORDER  = 3'd1;
    localparam logic [2:0] REG_SRC_DLY  = 3'd2;
    localparam logic [2:0] REG_HIST_SPN = 3'd3;
    localparam logic [2:0] REG_Y_PATS   = 3'd4;

    typedef struct packed {
        logic [2:0] x_order;
        logic [3:0] y_order;
        logic [5:0] source_delay;
        logic [4:0] history_span;
        logic [8:0] y_pattern_count;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        x_order:         3'd1,
        y_order:         4'd1,
        source_delay:    6'd0,
        history_span:    5'd2,
        y_pattern_count: 9'd2
    };

    typedef struct packed {
        logic             counted;
        logic [BIN_W-1:0] bin;
    } t_item;

endpackage

>>> src/spjh_ram.sv
// generic single write port ram with registered read
module spjh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/spjh_regs.sv
// configuration register bank behind the apb port
module spjh_regs import spjh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output logic [APB_DW-1:0] o_prdata,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign w_wr = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (w_wr) begin
            unique case (i_paddr[ADDR_W-1:2])
                REG_X_ORDER:  r_cfg.x_order         <= i_pwdata[2:0];
                REG_Y_ORDER:  r_cfg.y_order         <= i_pwdata[3:0];
                REG_SRC_DLY:  r_cfg.source_delay    <= i_pwdata[5:0];
                REG_HIST_SPN: r_cfg.history_span    <= i_pwdata[4:0];
                REG_Y_PATS:   r_cfg.y_pattern_count <= i_pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[ADDR_W-1:2])
            REG_X_ORDER:  o_prdata = APB_DW'(r_cfg.x_order);
            REG_Y_ORDER:  o_prdata = APB_DW'(r_cfg.y_order);
            REG_SRC_DLY:  o_prdata = APB_DW'(r_cfg.source_delay);
            REG_HIST_SPN: o_prdata = APB_DW'(r_cfg.history_span);
            REG_Y_PATS:   o_prdata = APB_DW'(r_cfg.y_pattern_count);
            default:      o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/spjh_front.sv
// spike histories, pattern codes and bin address stage
module spjh_front import spjh_pkg::*; #(
    parameter int MAX_X_ORDER = 7,
    parameter int MAX_Y_ORDER = 8,
    parameter int MAX_DELAY   = 63
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_clear_busy,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_req_type,
    input  logic             i_x_spike,
    input  logic             i_y_spike,
    input  logic [BIN_W-1:0] i_bin_index,
    output logic             o_item_valid,
    output t_item            o_item,
    input  logic             i_item_ready
);

    localparam int XC_W  = MAX_X_ORDER + 1;
    localparam int XO_W  = $clog2(MAX_X_ORDER + 1);
    localparam int YO_W  = $clog2(MAX_Y_ORDER + 1);
    localparam int TAU_W = $clog2(MAX_DELAY + 1);
    localparam int DL_W  = MAX_DELAY + MAX_Y_ORDER;

    logic [MAX_X_ORDER-1:0] r_th;
    logic [DL_W-1:0]        r_dl;
    logic [SIDX_W-1:0]      r_idx;

    logic                   r_s1_valid;
    logic                   r_s1_read;
    logic                   r_s1_count;
    logic [XC_W-1:0]        r_s1_xcode;
    logic [MAX_Y_ORDER-1:0] r_s1_ycode;
    logic [BIN_W-1:0]       r_s1_bin;

    logic [XO_W-1:0]        w_xo;
    logic [3:0]             w_yo_raw;
    logic [YO_W-1:0]        w_yo;
    logic [TAU_W-1:0]       w_tau;
    logic [MAX_X_ORDER-1:0] w_xrev;
    logic [XC_W-1:0]        w_xcode;
    logic [MAX_Y_ORDER-1:0] w_win;
    logic [MAX_Y_ORDER-1:0] w_yrev;
    logic [MAX_Y_ORDER-1:0] w_ycode;
    logic                   w_count;
    logic                   w_acc;
    logic                   w_s1_free;
    logic [XC_W+8:0]        w_prod;
    logic [BIN_W-1:0]       w_sum;

    always_comb begin
        if (32'(i_cfg.x_order) > MAX_X_ORDER) begin
            w_xo = XO_W'(MAX_X_ORDER);
        end else begin
            w_xo = XO_W'(i_cfg.x_order);
        end
        w_yo_raw = (i_cfg.y_order == 4'd0) ? 4'd1 : i_cfg.y_order;
        if (32'(w_yo_raw) > MAX_Y_ORDER) begin
            w_yo = YO_W'(MAX_Y_ORDER);
        end else begin
            w_yo = YO_W'(w_yo_raw);
        end
        if (32'(i_cfg.source_delay) > MAX_DELAY) begin
            w_tau = TAU_W'(MAX_DELAY);
        end else begin
            w_tau = TAU_W'(i_cfg.source_delay);
        end
        for (int j = 0; j < MAX_X_ORDER; j++) begin
            w_xrev[MAX_X_ORDER-1-j] = r_th[j];
        end
        w_xcode = {i_x_spike, w_xrev} >> (XO_W'(MAX_X_ORDER) - w_xo);
        w_win = MAX_Y_ORDER'(r_dl >> w_tau);
        for (int j = 0; j < MAX_Y_ORDER; j++) begin
            w_yrev[MAX_Y_ORDER-1-j] = w_win[j];
        end
        w_ycode = w_yrev >> (YO_W'(MAX_Y_ORDER) - w_yo);
        w_count = (32'(r_idx) + 32'd1) >= (32'(i_cfg.history_span) + 32'(w_tau));
    end

    assign w_s1_free = !r_s1_valid || i_item_ready;
    assign o_ready   = !i_clear_busy && w_s1_free;
    assign w_acc     = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_th       <= '0;
            r_dl       <= '0;
            r_idx      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_acc && !i_req_type) begin
                r_th <= MAX_X_ORDER'({r_th, i_x_spike});
                r_dl <= DL_W'({r_dl, i_y_spike});
                if (r_idx != '1) begin
                    r_idx <= r_idx + SIDX_W'(1);
                end
            end
            if (w_acc) begin
                r_s1_valid <= 1'b1;
            end else if (i_item_ready) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_read  <= i_req_type;
            r_s1_count <= !i_req_type && w_count;
            r_s1_xcode <= w_xcode;
            r_s1_ycode <= w_ycode;
            r_s1_bin   <= i_bin_index;
        end
    end

    // bin address from target code stride plus source code
    assign w_prod = r_s1_xcode * i_cfg.y_pattern_count;
    assign w_sum  = BIN_W'(w_prod) + BIN_W'(r_s1_ycode);

    assign o_item_valid   = r_s1_valid;
    assign o_item.counted = r_s1_count;
    assign o_item.bin     = r_s1_read ? r_s1_bin : w_sum;

endmodule

>>> src/spjh_update.sv
// histogram read-modify-write with forwarding, clearing pass and output register
module spjh_update import spjh_pkg::*; #(
    parameter int COUNT_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    input  t_item                i_item,
    output logic                 o_item_ready,
    output logic                 o_clear_busy,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_counted,
    output logic [BIN_W-1:0]     o_pattern_bin,
    output logic [CNT_OUT_W-1:0] o_bin_count
);

    logic                  r_clr_busy;
    logic [BIN_W-1:0]      r_clr_addr;

    logic                  r_s2_valid;
    t_item                 r_s2_item;
    logic                  r_s2_hit;
    logic [COUNT_BITS-1:0] r_s2_fwd;

    logic                  r_out_valid;
    t_item                 r_out_item;
    logic [CNT_OUT_W-1:0]  r_out_cnt;

    logic [COUNT_BITS-1:0] w_rdata;
    logic [COUNT_BITS-1:0] w_old;
    logic [COUNT_BITS-1:0] w_new;
    logic                  w_s2_fire;
    logic                  w_take;
    logic                  w_we;
    logic [BIN_W-1:0]      w_waddr;
    logic [COUNT_BITS-1:0] w_wdata;

    assign w_s2_fire    = r_s2_valid && (!r_out_valid || i_ready);
    assign o_item_ready = !r_s2_valid || w_s2_fire;
    assign w_take       = i_item_valid && o_item_ready;

    assign w_old = r_s2_hit ? r_s2_fwd : w_rdata;
    assign w_new = (r_s2_item.counted && (w_old != '1)) ? w_old + COUNT_BITS'(1) : w_old;

    assign w_we    = r_clr_busy || (w_s2_fire && r_s2_item.counted);
    assign w_waddr = r_clr_busy ? r_clr_addr : r_s2_item.bin;
    assign w_wdata = r_clr_busy ? '0 : w_new;

    spjh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_take),
        .i_raddr (i_item.bin),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + BIN_W'(1);
                if (r_clr_addr == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_take) begin
                r_s2_valid <= 1'b1;
            end else if (w_s2_fire) begin
                r_s2_valid <= 1'b0;
            end
            if (w_s2_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // the item leaving writes at the same edge the next one reads
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s2_item <= i_item;
            r_s2_hit  <= w_s2_fire && r_s2_item.counted && (r_s2_item.bin == i_item.bin);
            r_s2_fwd  <= w_new;
        end
        if (w_s2_fire) begin
            r_out_item <= r_s2_item;
            r_out_cnt  <= CNT_OUT_W'(w_new);
        end
    end

    assign o_clear_busy  = r_clr_busy;
    assign o_valid       = r_out_valid;
    assign o_counted     = r_out_item.counted;
    assign o_pattern_bin = r_out_item.bin;
    assign o_bin_count   = r_out_cnt;

endmodule

>>> src/spike_pattern_joint_histogram.sv
// top level of the spike pattern joint histogram
//
// input channel (i_valid / o_ready) carries either a spike sample (x and y bits of one
// time bin) or a read of one histogram bin; every transfer yields exactly one result on
// the output channel (o_valid / i_ready) with the addressed bin and its count after any
// increment. results leave in input order.
// each item is registered in the front stage, then the read stage, then the output register.
// throughput: one item per cycle while results are taken; the histogram memory has one read
// and one write port, and a count written by one item is forwarded to the next one at the
// same bin. after reset the histogram memory is cleared one bin per cycle, all 65536 bins,
// with o_ready low; configuration writes over apb are taken throughout. histories and the
// sample index reset to zero, registers to their defaults.
// when the receiver stalls, the output register holds its result and the two stages
// behind it keep filling, so o_ready drops only once all three are occupied.
// configuration is to be written only while no item is in flight.
module spike_pattern_joint_histogram import spjh_pkg::*; #(
    parameter int MAX_X_ORDER = 7,
    parameter int MAX_Y_ORDER = 8,
    parameter int MAX_DELAY   = 63,
    parameter int COUNT_BITS  = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_req_type,
    input  logic                 i_x_spike,
    input  logic                 i_y_spike,
    input  logic [BIN_W-1:0]     i_bin_index,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_counted,
    output logic [BIN_W-1:0]     o_pattern_bin,
    output logic [CNT_OUT_W-1:0] o_bin_count
);

    t_cfg  w_cfg;
    logic  w_clear_busy;
    logic  w_item_valid;
    logic  w_item_ready;
    t_item w_item;

    assign pready = 1'b1;

    spjh_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    spjh_front #(
        .MAX_X_ORDER (MAX_X_ORDER),
        .MAX_Y_ORDER (MAX_Y_ORDER),
        .MAX_DELAY   (MAX_DELAY)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_clear_busy (w_clear_busy),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_x_spike    (i_x_spike),
        .i_y_spike    (i_y_spike),
        .i_bin_index  (i_bin_index),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_ready (w_item_ready)
    );

    spjh_update #(
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (w_item_valid),
        .i_item        (w_item),
        .o_item_ready  (w_item_ready),
        .o_clear_busy  (w_clear_busy),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_counted     (o_counted),
        .o_pattern_bin (o_pattern_bin),
        .o_bin_count   (o_bin_count)
    );

endmodule
